@@ rtl/core/utf8_to_ucs2_hex_encoder_assert.svh @@
// Assertion macros for the UTF-8 to UCS-2 hex encoder RTL (used by u2h_queue).
// Expects a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef UTF8_TO_UCS2_HEX_ENCODER_ASSERT_SVH
`define UTF8_TO_UCS2_HEX_ENCODER_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define U2H_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// Condition must hold in the cycle after the trigger.
`define U2H_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

@@ rtl/core/u2h_pkg.sv @@
// Shared types, constants and helpers for the UTF-8 to UCS-2 hex encoder.
// No dependencies.
`default_nettype none

package u2h_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;

  localparam logic [1:0] LAST_DIGIT = 2'd3;

  typedef struct packed {
    logic [15:0] code;
    logic        last;
  } code_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [6:0] nibble_to_ascii(input logic [3:0] n);
    logic [6:0] r;
    if (n < 4'd10) begin
      r = 7'h30 + {3'b000, n};
    end else begin
      r = 7'h37 + {3'b000, n};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/u2h_front.sv @@
// Front end: accepts UTF-8 bytes, gathers multi-byte characters, pushes codes.
// Depends on u2h_pkg.
`default_nettype none

module u2h_front (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     s_tvalid,
  output logic                    s_tready,
  input  wire  [7:0]              s_tdata,   // [7:0] in_byte
  input  wire                     s_tlast,   // end_of_text
  input  u2h_pkg::queue_status_t  q_status,
  output logic                    push,
  output u2h_pkg::code_item_t     push_item
);
  import u2h_pkg::*;

  logic [1:0]  pending, pending_next, pending_dec;
  logic [15:0] acc, acc_next, merged, lead_bits;
  logic        emit;
  logic [15:0] code;
  logic        accept;

  assign s_tready = !q_status.full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    pending_next = pending;
    acc_next     = acc;
    emit         = 1'b0;
    code         = '0;
    pending_dec  = pending - 2'd1;
    merged       = (pending == 2'd2) ? (acc | {4'b0, s_tdata[5:0], 6'b0})
                                     : (acc | {10'b0, s_tdata[5:0]});
    lead_bits    = '0;
    if (pending != 2'd0) begin
      if (pending_dec == 2'd0 || s_tlast) begin
        emit         = 1'b1;
        code         = merged;
        pending_next = 2'd0;
        acc_next     = '0;
      end else begin
        pending_next = pending_dec;
        acc_next     = merged;
      end
    end else if ((s_tdata & ASCII_MASK) == 8'h00) begin
      emit = 1'b1;
      code = {8'b0, s_tdata};
    end else if ((s_tdata & LEAD2_MASK) == LEAD2_CODE ||
                 (s_tdata & LEAD3_MASK) == LEAD3_CODE) begin
      if ((s_tdata & LEAD2_MASK) == LEAD2_CODE) begin
        lead_bits    = {5'b0, s_tdata[4:0], 6'b0};
        pending_next = 2'd1;
      end else begin
        lead_bits    = {s_tdata[3:0], 12'b0};
        pending_next = 2'd2;
      end
      acc_next = lead_bits;
      // cut short by end of text: emit what is gathered and drop back to idle
      if (s_tlast) begin
        emit         = 1'b1;
        code         = lead_bits;
        pending_next = 2'd0;
        acc_next     = '0;
      end
    end else begin
      // stray continuation or four-byte / invalid lead
      emit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
      acc     <= '0;
    end else if (accept) begin
      pending <= pending_next;
      acc     <= acc_next;
    end
  end

  assign push           = accept && emit;
  assign push_item.code = code;
  assign push_item.last = s_tlast;

endmodule

`default_nettype wire

@@ rtl/core/u2h_queue.sv @@
// Short register queue of character codes between front and back ends.
// Depends on u2h_pkg and utf8_to_ucs2_hex_encoder_assert.svh.
`default_nettype none
`include "utf8_to_ucs2_hex_encoder_assert.svh"

module u2h_queue #(
  parameter int DEPTH = u2h_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     push,
  input  u2h_pkg::code_item_t     push_item,
  input  wire                     pop,
  output u2h_pkg::code_item_t     head,
  output u2h_pkg::queue_status_t  status
);
  import u2h_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  code_item_t        slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `U2H_ASSERT_NOW(a_no_push_full, push, !status.full || pop, "push into full queue")
  `U2H_ASSERT_NOW(a_no_pop_empty, pop, !status.empty, "pop from empty queue")
  `U2H_ASSERT_NEXT(a_push_fills, push && !pop, !status.empty, "queue empty after push")
  `U2H_ASSERT_NOW(a_count_range, 1'b1, count <= CNT_W'(DEPTH), "queue count out of range")

endmodule

`default_nettype wire

@@ rtl/core/u2h_back.sv @@
// Back end: takes codes from the queue and streams four hex digits each.
// Depends on u2h_pkg.
`default_nettype none

module u2h_back (
  input  wire                     clk,
  input  wire                     rst,
  input  u2h_pkg::code_item_t     head,
  input  u2h_pkg::queue_status_t  q_status,
  output logic                    pop,
  output logic                    m_tvalid,
  input  wire                     m_tready,
  output logic [7:0]              m_tdata,   // [6:0] hex_char, [7] zero
  output logic                    m_tuser,   // group_end
  output logic                    m_tlast    // text_end
);
  import u2h_pkg::*;

  logic        busy;
  logic [15:0] code;
  logic        last;
  logic [1:0]  digit;
  logic [3:0]  nibble;
  logic        take;
  logic        final_digit;

  assign take        = m_tvalid && m_tready;
  assign final_digit = (digit == LAST_DIGIT);
  assign pop         = !q_status.empty && (!busy || (take && final_digit));

  always_comb begin
    case (digit)
      2'd0:    nibble = code[15:12];
      2'd1:    nibble = code[11:8];
      2'd2:    nibble = code[7:4];
      default: nibble = code[3:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      digit <= 2'd0;
    end else if (pop) begin
      busy  <= 1'b1;
      digit <= 2'd0;
    end else if (take) begin
      // advance to the next digit, or go idle after the last one
      if (final_digit) begin
        busy <= 1'b0;
      end
      digit <= digit + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      code <= head.code;
      last <= head.last;
    end
  end

  assign m_tvalid = busy;
  assign m_tdata  = {1'b0, nibble_to_ascii(nibble)};
  assign m_tuser  = final_digit;
  assign m_tlast  = final_digit && last;

endmodule

`default_nettype wire

@@ rtl/core/utf8_to_ucs2_hex_encoder.sv @@
// Top level of the UTF-8 to UCS-2 hex encoder: front end, code queue, back end.
// Depends on u2h_pkg, u2h_front, u2h_queue, u2h_back.
//
//  channel | dir | tdata           | tuser     | tlast
//  s_*     | in  | in_byte[7:0]    | -         | end_of_text
//  m_*     | out | hex_char[6:0]   | group_end | text_end
//
// Each character code gives four digits, one per cycle while the result side
// does not stall; the back end's digit counter steps through them.
// Bytes are taken one per cycle while the code queue has room (QUEUE_DEPTH).
// Reset is synchronous; no clearing pass.
// A stall on the result side holds the digit; the front keeps taking bytes
// until the queue fills.
`default_nettype none

module utf8_to_ucs2_hex_encoder #(
  parameter int QUEUE_DEPTH = u2h_pkg::QUEUE_DEPTH_DEF
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire  [7:0] s_tdata,   // [7:0] in_byte
  input  wire        s_tlast,   // end_of_text
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [7:0] m_tdata,   // [6:0] hex_char, [7] zero
  output logic       m_tuser,   // group_end
  output logic       m_tlast    // text_end
);
  import u2h_pkg::*;

  logic          push, pop;
  code_item_t    push_item, head;
  queue_status_t q_status;

  u2h_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  u2h_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  u2h_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

@@ bench/utf8_to_ucs2_hex_encoder_test.sv @@
// Self-checking bench for the UTF-8 to UCS-2 hex encoder: drives UTF-8 bytes, predicts the hex
// digits of each character code and checks the digit stream in order.
// Depends on utf8_to_ucs2_hex_encoder and u2h_pkg.
`default_nettype none

module utf8_to_ucs2_hex_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import u2h_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int BYTES_PER_PASS = 64;
  localparam int DRAIN_CYCLES   = 16;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       eot;
  } text_byte_t;

  typedef struct packed {
    logic [6:0] hex;
    logic       grp;
    logic       txt;
  } hex_digit_t;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tuser;
  logic       m_tlast;

  text_byte_t pending_bytes[$];
  hex_digit_t expected_digits[$];

  // Own copy of the decoder state
  logic [1:0]  cont_left;
  logic [15:0] code_bits;

  int  idle_pct;
  int  stall_pct;
  bit  s_taken;
  int  cycles;
  int  mismatches;
  int  bytes_taken;
  int  digits_seen;
  int  texts_ended;

  utf8_to_ucs2_hex_encoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [6:0] hex_of_nibble(input logic [3:0] n);
    if (n < 4'd10) begin
      return 7'(8'd48 + n);
    end
    return 7'(8'd65 + n - 4'd10);
  endfunction

  // Update the decoder state for one byte; queue four digits when a code is complete.
  function automatic void predict_digits(input logic [7:0] b, input logic eot);
    logic        done;
    logic [15:0] code;
    int          k;
    done = 1'b0;
    code = 16'h0000;
    if (cont_left != 2'd0) begin
      code_bits = code_bits | (16'(b[5:0]) << (6 * (int'(cont_left) - 1)));
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0 || eot) begin
        code = code_bits;
        done = 1'b1;
      end
    end else if ((b & ASCII_MASK) == 8'h00) begin
      code = {8'h00, b};
      done = 1'b1;
    end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      code_bits = {5'd0, b[4:0], 6'd0};
      cont_left = 2'd1;
      code      = code_bits;
      done      = eot;
    end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      code_bits = {b[3:0], 12'd0};
      cont_left = 2'd2;
      code      = code_bits;
      done      = eot;
    end else begin
      done = 1'b1;
    end
    if (done) begin
      cont_left = 2'd0;
      code_bits = 16'h0000;
      for (k = 0; k < 4; k++) begin
        expected_digits.push_back('{hex: hex_of_nibble(code[15 - 4 * k -: 4]),
                                    grp: (k == 3), txt: (k == 3) && eot});
      end
    end
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic eot);
    pending_bytes.push_back('{data: b, eot: eot});
  endtask

  function automatic logic [7:0] cont_byte();
    // mostly proper continuation bytes, now and then any byte at all
    if ($urandom_range(99) < 12) begin
      return 8'($urandom_range(255));
    end
    return {2'b10, 6'($urandom_range(63))};
  endfunction

  // One random character: well-formed most of the time, otherwise noise or cut short.
  task automatic push_random_char();
    int  kind;
    int  n;
    int  cut;
    int  i;
    logic [7:0] b;
    kind = $urandom_range(99);
    cut  = ($urandom_range(99) < 5) ? 1 : 0;
    if (kind < 30) begin
      push_byte(8'($urandom_range(127)), $urandom_range(99) < 8);
    end else if (kind < 80) begin
      n = (kind < 55) ? 2 : 3;
      b = (n == 2) ? {3'b110, 5'($urandom_range(31))} : {4'b1110, 4'($urandom_range(15))};
      for (i = 0; i < n; i++) begin
        if (cut && i == $urandom_range(n - 2)) begin
          push_byte(b, 1'b1);
          break;
        end
        push_byte(b, (i == n - 1) && ($urandom_range(99) < 8));
        b = cont_byte();
      end
    end else if (kind < 88) begin
      push_byte({2'b10, 6'($urandom_range(63))}, $urandom_range(99) < 8);
    end else if (kind < 95) begin
      push_byte({4'b1111, 4'($urandom_range(15))}, $urandom_range(99) < 8);
    end else begin
      push_byte(8'($urandom_range(255)), $urandom_range(99) < 8);
    end
  endtask

  task automatic push_directed();
    push_byte(8'h41, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hC3, 1'b0);
    push_byte(8'hA9, 1'b0);
    push_byte(8'hDF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hE2, 1'b0);
    push_byte(8'h82, 1'b0);
    push_byte(8'hAC, 1'b0);
    push_byte(8'hEF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    // stray continuation bytes
    push_byte(8'h80, 1'b0);
    push_byte(8'hBF, 1'b0);
    // four-byte and invalid leads
    push_byte(8'hF0, 1'b0);
    push_byte(8'hFF, 1'b0);
    // continuation slot taking a byte with the wrong top bits
    push_byte(8'hC3, 1'b0);
    push_byte(8'h41, 1'b0);
    // sequences cut short by the end of text
    push_byte(8'hC5, 1'b1);
    push_byte(8'hE2, 1'b0);
    push_byte(8'h82, 1'b1);
    push_byte(8'hE2, 1'b1);
    push_byte(8'h5A, 1'b1);
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch at cycle %0d: %s", cycles, what);
    end
  endtask

  // Driver: hold a request until taken, then advance or idle.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
        s_tdata  <= pending_bytes[0].data;
        s_tlast  <= pending_bytes[0].eot;
        s_tvalid <= 1'b1;
        void'(pending_bytes.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: predict on each accepted byte, check each accepted digit.
  always @(posedge clk) begin
    hex_digit_t want;
    cycles++;
    s_taken = !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (s_taken) begin
        predict_digits(s_tdata, s_tlast);
        bytes_taken++;
      end
      if (m_tvalid && m_tready) begin
        digits_seen++;
        if (m_tlast) begin
          texts_ended++;
        end
        if (expected_digits.size() == 0) begin
          note_mismatch($sformatf("unexpected digit data=%h group_end=%b text_end=%b",
                                  m_tdata, m_tuser, m_tlast));
        end else begin
          want = expected_digits.pop_front();
          if (m_tdata !== {1'b0, want.hex} || m_tuser !== want.grp ||
              m_tlast !== want.txt) begin
            note_mismatch($sformatf(
              "expected data=%h group_end=%b text_end=%b, got data=%h group_end=%b text_end=%b",
              {1'b0, want.hex}, want.grp, want.txt, m_tdata, m_tuser, m_tlast));
          end
        end
      end
    end
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d digits outstanding", cycles,
             expected_digits.size());
    $display("[utf8_to_ucs2_hex_encoder] ERROR");
    $finish;
  end

  initial begin
    int pass;
    int base;
    cycles      = 0;
    mismatches  = 0;
    bytes_taken = 0;
    digits_seen = 0;
    texts_ended = 0;
    s_taken     = 1'b0;
    cont_left   = 2'd0;
    code_bits   = 16'h0000;
    idle_pct    = 0;
    stall_pct   = 0;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = 8'h00;
    s_tlast     = 1'b0;
    m_tready    = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (pass = 0; pass < 4; pass++) begin
      case (pass)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      if (pass == 0) begin
        push_directed();
      end
      base = pending_bytes.size();
      while (pending_bytes.size() < base + BYTES_PER_PASS) begin
        push_random_char();
      end
      // drain before the idling pattern changes
      do @(posedge clk);
      while (pending_bytes.size() != 0 || s_tvalid || expected_digits.size() != 0);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d bytes, %0d digits and %0d ends of text over four idling patterns",
             bytes_taken, digits_seen, texts_ended);
    $display("mismatches: %0d, digits still expected: %0d", mismatches,
             expected_digits.size());
    if (mismatches == 0 && expected_digits.size() == 0) begin
      $display("[utf8_to_ucs2_hex_encoder] OK");
    end else begin
      $display("[utf8_to_ucs2_hex_encoder] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ utf8_to_ucs2_hex_encoder.f @@
+incdir+rtl/core
rtl/core/u2h_pkg.sv
rtl/core/u2h_front.sv
rtl/core/u2h_queue.sv
rtl/core/u2h_back.sv
rtl/core/utf8_to_ucs2_hex_encoder.sv
bench/utf8_to_ucs2_hex_encoder_test.sv
